>>> rtl/priority_request_queue_banked_memory_assert.svh
// Assertion macros for the request scheduler.
`ifndef PRIORITY_REQUEST_QUEUE_BANKED_MEMORY_ASSERT_SVH
`define PRIORITY_REQUEST_QUEUE_BANKED_MEMORY_ASSERT_SVH

`ifndef SYNTHESIS
`define PRQBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prqbm: same-cycle check failed");
`define PRQBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prqbm: next-cycle check failed");
`else
`define PRQBM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PRQBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/prqbm_pkg.sv
package prqbm_pkg;

  localparam int QUEUE_DEPTH     = 16;
  localparam int PRIORITY_LEVELS = 5;
  localparam int BANK_WORDS      = 256;
  localparam int BANK_COUNT      = 4;
  localparam int MEM_WORDS       = BANK_WORDS * BANK_COUNT;

  localparam int ADDR_W  = 11;
  localparam int DATA_W  = 32;
  localparam int COORD_W = 3;
  localparam int PRIO_W  = 3;
  localparam int STAT_W  = 2;

  localparam int QIDX_W  = $clog2(PRIORITY_LEVELS);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int BANK_W  = $clog2(BANK_WORDS);
  localparam int BSEL_W  = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int AEXT_W  = 16;

  localparam logic [STAT_W-1:0] RSP_QUEUED  = 2'd0;
  localparam logic [STAT_W-1:0] RSP_DROPPED = 2'd1;
  localparam logic [STAT_W-1:0] RSP_SERVED  = 2'd2;
  localparam logic [STAT_W-1:0] RSP_EMPTY   = 2'd3;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_DROP,
    OP_SERVE
  } op_kind_t;

  typedef struct packed {
    logic               wr;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } entry_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [QIDX_W-1:0] qidx;
    entry_t            entry;
  } op_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
    ptr_next = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

endpackage

>>> rtl/prqbm_in_if.sv
interface prqbm_in_if import prqbm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [PRIO_W-1:0]        priority_req;
  logic                     is_write;
  logic [ADDR_W-1:0]        address;
  logic signed [DATA_W-1:0] write_data;
  logic [COORD_W-1:0]       requester_x;
  logic [COORD_W-1:0]       requester_y;

  modport source (
    output valid, command, priority_req, is_write, address, write_data,
           requester_x, requester_y,
    input  ready
  );
  modport sink (
    input  valid, command, priority_req, is_write, address, write_data,
           requester_x, requester_y,
    output ready
  );
endinterface

>>> rtl/prqbm_out_if.sv
interface prqbm_out_if import prqbm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic                     served_write;
  logic [ADDR_W-1:0]        served_address;
  logic signed [DATA_W-1:0] response_data;
  logic [COORD_W-1:0]       reply_x;
  logic [COORD_W-1:0]       reply_y;

  modport source (
    output valid, status, served_write, served_address, response_data,
           reply_x, reply_y,
    input  ready
  );
  modport sink (
    input  valid, status, served_write, served_address, response_data,
           reply_x, reply_y,
    output ready
  );
endinterface

>>> rtl/prqbm_front.sv
module prqbm_front import prqbm_pkg::*; (
  prqbm_in_if.sink in_req,
  input  logic     clearing,
  input  logic     fifo_full,
  output logic     push_valid,
  output op_t      push_op
);

  logic [PRIO_W:0] prio_ext;
  logic            prio_ok;

  assign prio_ext = {1'b0, in_req.priority_req};
  assign prio_ok  = (prio_ext != '0) && (prio_ext <= (PRIO_W + 1)'(PRIORITY_LEVELS));

  assign in_req.ready = !fifo_full && !clearing;
  assign push_valid   = in_req.valid && in_req.ready;

  always_comb begin
    push_op.qidx       = QIDX_W'(prio_ext - (PRIO_W + 1)'(1));
    push_op.entry.wr   = in_req.is_write;
    push_op.entry.addr = in_req.address;
    push_op.entry.data = in_req.write_data;
    push_op.entry.x    = in_req.requester_x;
    push_op.entry.y    = in_req.requester_y;
    if (in_req.command) begin
      push_op.kind = OP_SERVE;
    end else if (prio_ok) begin
      push_op.kind = OP_PUSH;
    end else begin
      push_op.kind = OP_DROP;
    end
  end

endmodule

>>> rtl/prqbm_cmd_fifo.sv
module prqbm_cmd_fifo import prqbm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output logic full,
  output logic pop_valid,
  output op_t  pop_op
);

  op_t        slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_op    = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = !wptr_r;
    end
    if (pop) begin
      rptr_nxt = !rptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_op;
    end
  end

endmodule

>>> rtl/prqbm_back.sv
`include "priority_request_queue_banked_memory_assert.svh"

module prqbm_back import prqbm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic op_valid,
  input  op_t  op,
  output logic op_pop,
  output logic clearing,
  prqbm_out_if.source out_rsp
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_FETCH,
    ST_ACCESS
  } state_t;

  state_t             state_r, state_nxt;
  logic [BANK_W-1:0]  clr_r, clr_nxt;

  logic [PTR_W-1:0]   head_r  [PRIORITY_LEVELS];
  logic [PTR_W-1:0]   head_nxt[PRIORITY_LEVELS];
  logic [PTR_W-1:0]   tail_r  [PRIORITY_LEVELS];
  logic [PTR_W-1:0]   tail_nxt[PRIORITY_LEVELS];
  logic [CNT_W-1:0]   cnt_r   [PRIORITY_LEVELS];
  logic [CNT_W-1:0]   cnt_nxt [PRIORITY_LEVELS];

  entry_t             hold_r, hold_nxt;
  logic               inr_r, inr_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic               out_wr_r, out_wr_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [COORD_W-1:0] out_x_r, out_x_nxt;
  logic [COORD_W-1:0] out_y_r, out_y_nxt;

  // queue store and bank store
  entry_t             qmem [PRIORITY_LEVELS][QUEUE_DEPTH];
  entry_t             qrd_r;
  logic [DATA_W-1:0]  bmem [BANK_COUNT][BANK_WORDS];
  logic [DATA_W-1:0]  brd_r;

  logic               out_free;
  logic               any_req;
  logic [QIDX_W-1:0]  sel_q;
  logic               q_full;
  logic               q_we;
  logic               q_re;

  logic [AEXT_W-1:0]  acc_addr;
  logic               acc_inr;
  logic [BSEL_W-1:0]  acc_bank;
  logic [BANK_W-1:0]  acc_off;
  logic               acc_we;
  logic               acc_re;

  assign clearing = (state_r == ST_CLEAR);
  assign out_free = !out_valid_r || out_rsp.ready;
  assign op_pop   = (state_r == ST_RUN) && op_valid && out_free;
  assign q_full   = (cnt_r[op.qidx] == CNT_W'(QUEUE_DEPTH));
  assign q_we     = op_pop && (op.kind == OP_PUSH) && !q_full;
  assign q_re     = op_pop && (op.kind == OP_SERVE) && any_req;

  // highest non-empty queue wins
  always_comb begin
    any_req = 1'b0;
    sel_q   = '0;
    for (int q = 0; q < PRIORITY_LEVELS; q++) begin
      if (cnt_r[q] != '0) begin
        any_req = 1'b1;
        sel_q   = QIDX_W'(q);
      end
    end
  end

  assign acc_addr = AEXT_W'(qrd_r.addr);
  assign acc_inr  = acc_addr < AEXT_W'(MEM_WORDS);
  assign acc_bank = BSEL_W'(acc_addr >> BANK_W);
  assign acc_off  = BANK_W'(acc_addr);
  assign acc_re   = (state_r == ST_FETCH);
  assign acc_we   = acc_re && acc_inr && qrd_r.wr;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    hold_nxt       = hold_r;
    inr_nxt        = inr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_wr_nxt     = out_wr_r;
    out_addr_nxt   = out_addr_r;
    out_data_nxt   = out_data_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + BANK_W'(1);
        if (clr_r == BANK_W'(BANK_WORDS - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (op_pop) begin
          out_wr_nxt   = 1'b0;
          out_addr_nxt = '0;
          out_data_nxt = '0;
          out_x_nxt    = '0;
          out_y_nxt    = '0;
          case (op.kind)
            OP_PUSH: begin
              out_valid_nxt = 1'b1;
              if (q_full) begin
                out_status_nxt = RSP_DROPPED;
              end else begin
                out_status_nxt     = RSP_QUEUED;
                tail_nxt[op.qidx]  = ptr_next(tail_r[op.qidx]);
                cnt_nxt[op.qidx]   = cnt_r[op.qidx] + CNT_W'(1);
              end
            end
            OP_SERVE: begin
              if (any_req) begin
                head_nxt[sel_q] = ptr_next(head_r[sel_q]);
                cnt_nxt[sel_q]  = cnt_r[sel_q] - CNT_W'(1);
                state_nxt       = ST_FETCH;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = RSP_EMPTY;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = RSP_DROPPED;
            end
          endcase
        end
      end
      ST_FETCH: begin
        hold_nxt  = qrd_r;
        inr_nxt   = acc_inr;
        state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = RSP_SERVED;
        out_wr_nxt     = hold_r.wr;
        out_addr_nxt   = hold_r.addr;
        out_x_nxt      = hold_r.x;
        out_y_nxt      = hold_r.y;
        if (!inr_r) begin
          out_data_nxt = '0;
        end else if (hold_r.wr) begin
          out_data_nxt = hold_r.data;
        end else begin
          out_data_nxt = brd_r;
        end
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int q = 0; q < PRIORITY_LEVELS; q++) begin
        head_r[q] <= '0;
        tail_r[q] <= '0;
        cnt_r[q]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
    end
    hold_r       <= hold_nxt;
    inr_r        <= inr_nxt;
    out_status_r <= out_status_nxt;
    out_wr_r     <= out_wr_nxt;
    out_addr_r   <= out_addr_nxt;
    out_data_r   <= out_data_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[op.qidx][tail_r[op.qidx]] <= op.entry;
    end
    if (q_re) begin
      qrd_r <= qmem[sel_q][head_r[sel_q]];
    end
  end

  // all banks cleared in parallel after reset, one offset a cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      for (int b = 0; b < BANK_COUNT; b++) begin
        bmem[b][clr_r] <= '0;
      end
    end else if (acc_we) begin
      bmem[acc_bank][acc_off] <= qrd_r.data;
    end
    if (acc_re) begin
      brd_r <= bmem[acc_bank][acc_off];
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.served_write   = out_wr_r;
  assign out_rsp.served_address = out_addr_r;
  assign out_rsp.response_data  = out_data_r;
  assign out_rsp.reply_x        = out_x_r;
  assign out_rsp.reply_y        = out_y_r;

  `PRQBM_ASSERT_NOW(a_no_out_in_flight, clk, rst_n, state_r == ST_FETCH || state_r == ST_ACCESS, !out_valid_r)
  `PRQBM_ASSERT_NOW(a_pop_only_run, clk, rst_n, op_pop, state_r == ST_RUN)
  `PRQBM_ASSERT_NOW(a_quiet_clear, clk, rst_n, state_r == ST_CLEAR, !out_valid_r && !op_pop)
  `PRQBM_ASSERT_NEXT(a_fetch_access, clk, rst_n, state_r == ST_FETCH, state_r == ST_ACCESS)
  `PRQBM_ASSERT_NEXT(a_serve_result, clk, rst_n, state_r == ST_ACCESS, out_valid_r && out_status_r == RSP_SERVED)

endmodule

>>> rtl/priority_request_queue_banked_memory.sv
// Push, drop, and serves with all queues empty: command queue, then the result register.
// Served requests: command queue, queue RAM read, bank RAM access, then the result register.
// One push per cycle while results are taken; later commands wait until a serve's RAM reads end.
// A two-entry command queue keeps input accepted while a result waits at the output.
// Reset: queues empty; a pass over the BANK_WORDS (256) offsets zeroes the banks, input held off.
module priority_request_queue_banked_memory import prqbm_pkg::*; (
  input logic clk,
  input logic rst_n,
  prqbm_in_if.sink    in_req,
  prqbm_out_if.source out_rsp
);

  logic clearing;
  logic fifo_full;
  logic push_valid;
  op_t  push_op;
  logic op_valid;
  op_t  op;
  logic op_pop;

  prqbm_front u_front (
    .in_req     (in_req),
    .clearing   (clearing),
    .fifo_full  (fifo_full),
    .push_valid (push_valid),
    .push_op    (push_op)
  );

  prqbm_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_op   (push_op),
    .pop       (op_pop),
    .full      (fifo_full),
    .pop_valid (op_valid),
    .pop_op    (op)
  );

  prqbm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .clearing (clearing),
    .out_rsp  (out_rsp)
  );

endmodule

>>> verif/priority_request_queue_banked_memory_tb.sv
`timescale 1ns / 1ps

module priority_request_queue_banked_memory_tb import prqbm_pkg::*;;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_SERVE = 1'b1;

  localparam int MAX_WAIT      = 16;
  localparam int RANDOM_ITEMS  = 620;
  localparam int STUCK_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic               command;
    logic [PRIO_W-1:0]  prio;
    logic               wr;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               wr;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  prqbm_in_if  in_req();
  prqbm_out_if out_rsp();

  priority_request_queue_banked_memory dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #2 clk = ~clk;

  // scheduler image: one FIFO per level, level 0 is priority 1
  entry_t            level_fifo [PRIORITY_LEVELS][$];
  logic [DATA_W-1:0] bank_image [MEM_WORDS] = '{default: '0};
  reply_t            owed_replies[$];

  int  mismatches   = 0;
  int  stuck_cycles = 0;
  bit  send_idle_en = 1'b1;
  bit  take_idle_en = 1'b1;

  function automatic reply_t file_or_serve(input request_t c);
    reply_t r;
    entry_t e;
    int     lvl;
    r = '0;
    if (c.command == CMD_PUSH) begin
      lvl = int'(c.prio) - 1;
      if (c.prio == 0 || c.prio > PRIORITY_LEVELS ||
          level_fifo[lvl].size() >= QUEUE_DEPTH) begin
        r.status = RSP_DROPPED;
      end else begin
        e.wr   = c.wr;
        e.addr = c.addr;
        e.data = c.data;
        e.x    = c.x;
        e.y    = c.y;
        level_fifo[lvl] = {level_fifo[lvl], e};
        r.status = RSP_QUEUED;
      end
      return r;
    end
    r.status = RSP_EMPTY;
    for (lvl = PRIORITY_LEVELS - 1; lvl >= 0; lvl--) begin
      if (level_fifo[lvl].size() != 0) begin
        e = level_fifo[lvl].pop_front();
        r.status = RSP_SERVED;
        r.wr     = e.wr;
        r.addr   = e.addr;
        r.x      = e.x;
        r.y      = e.y;
        if (e.addr < MEM_WORDS) begin
          if (e.wr) bank_image[e.addr] = e.data;
          r.data = bank_image[e.addr];
        end
        return r;
      end
    end
    return r;
  endfunction

  function automatic int draw_wait(input bit enabled);
    if (!enabled || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic int queued_total();
    int n;
    n = 0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) n += level_fifo[i].size();
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] hot [8] = '{11'd0, 11'd255, 11'd256, 11'd511,
                                   11'd512, 11'd767, 11'd768, 11'd1023};
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return hot[$urandom_range(0, 7)];
    if (sel < 6) return ADDR_W'($urandom_range(0, 15) * 64);
    if (sel < 9) return ADDR_W'($urandom_range(0, MEM_WORDS - 1));
    return ADDR_W'($urandom_range(MEM_WORDS, 2047));
  endfunction

  function automatic logic [PRIO_W-1:0] pick_priority();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return PRIO_W'($urandom_range(PRIORITY_LEVELS + 1, 7));
    return PRIO_W'($urandom_range(1, PRIORITY_LEVELS));
  endfunction

  task automatic send_request(input request_t c);
    int gap;
    gap = draw_wait(send_idle_en);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.command      <= c.command;
    in_req.priority_req <= c.prio;
    in_req.is_write     <= c.wr;
    in_req.address      <= c.addr;
    in_req.write_data   <= c.data;
    in_req.requester_x  <= c.x;
    in_req.requester_y  <= c.y;
    @(posedge clk);
    while (in_req.ready !== 1'b1) @(posedge clk);
    owed_replies = {owed_replies, file_or_serve(c)};
  endtask

  task automatic push_req(input logic [PRIO_W-1:0] prio, input logic wr,
                          input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data,
                          input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    request_t c;
    c.command = CMD_PUSH;
    c.prio    = prio;
    c.wr      = wr;
    c.addr    = addr;
    c.data    = data;
    c.x       = x;
    c.y       = y;
    send_request(c);
  endtask

  // fields other than the command are don't-care on a serve, so fill with junk
  task automatic serve_req();
    request_t c;
    c         = request_t'({$urandom, $urandom});
    c.command = CMD_SERVE;
    send_request(c);
  endtask

  task automatic push_random(input logic [PRIO_W-1:0] prio);
    push_req(prio, 1'($urandom), pick_address(), $urandom,
             COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic test_bad_priority();
    push_req(3'd0, 1'b1, 11'd5, 32'h1234_5678, 3'd1, 3'd2);
    push_req(3'd6, 1'b1, 11'd5, 32'h8765_4321, 3'd3, 3'd4);
    push_req(3'd7, 1'b1, 11'd5, 32'hffff_ffff, 3'd7, 3'd7);
  endtask

  task automatic test_memory_extremes();
    push_req(3'd5, 1'b1, 11'd0,    32'h7fff_ffff, 3'd0, 3'd0);
    push_req(3'd5, 1'b1, 11'd1023, 32'h8000_0000, 3'd7, 3'd7);
    push_req(3'd5, 1'b1, 11'd1024, 32'hffff_ffff, 3'd3, 3'd4);
    push_req(3'd5, 1'b1, 11'd2047, 32'hdead_beef, 3'd4, 3'd3);
    repeat (4) serve_req();
    push_req(3'd2, 1'b0, 11'd0,    32'hffff_ffff, 3'd7, 3'd0);
    push_req(3'd2, 1'b0, 11'd1023, 32'h0000_0000, 3'd0, 3'd7);
    push_req(3'd2, 1'b0, 11'd2047, 32'h5555_aaaa, 3'd5, 3'd2);
    repeat (3) serve_req();
  endtask

  // one request per level, served highest first, then one serve with nothing left
  task automatic test_priority_order();
    for (int lvl = 1; lvl <= PRIORITY_LEVELS; lvl++) begin
      push_req(PRIO_W'(lvl), 1'b0, ADDR_W'(lvl * 200), $urandom,
               COORD_W'(lvl), COORD_W'(7 - lvl));
    end
    repeat (PRIORITY_LEVELS + 1) serve_req();
  endtask

  task automatic test_random_traffic();
    int sent;
    int kind;
    int lvl;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) begin
        send_idle_en = ($urandom_range(0, 2) != 0);
        take_idle_en = ($urandom_range(0, 2) != 0);
      end
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        n = $urandom_range(1, 12);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) serve_req();
          else push_random(pick_priority());
        end
      end else if (kind < 8) begin
        // run one level past full
        lvl = $urandom_range(1, PRIORITY_LEVELS);
        n   = QUEUE_DEPTH - level_fifo[lvl - 1].size() + $urandom_range(1, 3);
        repeat (n) push_random(PRIO_W'(lvl));
      end else begin
        n = queued_total() + $urandom_range(1, 3);
        repeat (n) serve_req();
      end
      sent += n;
    end
  endtask

  initial begin : response_taker
    int stall;
    out_rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_wait(take_idle_en);
      if (stall > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      do @(posedge clk); while (out_rsp.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : reply_check
    reply_t want;
    reply_t got;
    if (rst_n === 1'b1 && out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
      got = {out_rsp.status, out_rsp.served_write, out_rsp.served_address,
             out_rsp.response_data, out_rsp.reply_x, out_rsp.reply_y};
      if (owed_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected reply: status %0d wr %0d addr %0d data %h x %0d y %0d",
                   got.status, got.wr, got.addr, got.data, got.x, got.y);
      end else begin
        want = owed_replies.pop_front();
        if (got.status !== want.status || got.wr !== want.wr || got.addr !== want.addr ||
            got.data !== want.data || got.x !== want.x || got.y !== want.y) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("reply mismatch: expected status %0d wr %0d addr %0d data %h x %0d y %0d",
                     want.status, want.wr, want.addr, want.data, want.x, want.y);
            $display("                actual   status %0d wr %0d addr %0d data %h x %0d y %0d",
                     got.status, got.wr, got.addr, got.data, got.x, got.y);
          end
        end
      end
    end
  end

  // bank clearing after reset holds input off; STUCK_LIMIT allows for it
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_req.valid === 1'b1 && in_req.ready === 1'b1) ||
          (out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("priority_request_queue_banked_memory_tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n               <= 1'b0;
    in_req.valid        <= 1'b0;
    in_req.command      <= CMD_PUSH;
    in_req.priority_req <= '0;
    in_req.is_write     <= 1'b0;
    in_req.address      <= '0;
    in_req.write_data   <= '0;
    in_req.requester_x  <= '0;
    in_req.requester_y  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_bad_priority();
    test_memory_extremes();
    test_priority_order();
    test_random_traffic();

    in_req.valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed_replies.size() == 0) begin
      $display("priority_request_queue_banked_memory_tb passed");
    end else begin
      $display("priority_request_queue_banked_memory_tb failed");
    end
    $finish;
  end

endmodule
